/* design/nept_pkg.sv */
`default_nettype none
package nept_pkg;

  // Field widths
  localparam int unsigned GaW    = 48;
  localparam int unsigned PaW    = 52;
  localparam int unsigned FrameW = 40;
  localparam int unsigned RegW   = 64;
  localparam int unsigned IdxW   = 9;

  // Level numbering
  localparam logic [1:0] LvlTop  = 2'd0;
  localparam logic [1:0] Lvl1G   = 2'd1;
  localparam logic [1:0] Lvl2M   = 2'd2;
  localparam logic [1:0] LvlLeaf = 2'd3;

  // Entry bit positions and masks
  localparam int unsigned BitLarge = 7;
  localparam logic [63:0] AddrMask = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] Addr1G   = 64'h000f_ffff_c000_0000;
  localparam logic [63:0] Addr2M   = 64'h000f_ffff_ffe0_0000;
  localparam logic [63:0] Rsv1G    = 64'h0000_0000_3fff_f000;
  localparam logic [63:0] Rsv2M    = 64'h0000_0000_001f_f000;
  localparam logic [63:0] Off1G    = 64'h0000_0000_3fff_ffff;
  localparam logic [63:0] Off2M    = 64'h0000_0000_001f_ffff;
  localparam logic [63:0] Off4K    = 64'h0000_0000_0000_0fff;

  typedef enum logic [1:0] {
    ACC_READ    = 2'd0,
    ACC_WRITE   = 2'd1,
    ACC_EXEC    = 2'd2,
    ACC_INVALID = 2'd3
  } access_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ACC   = 3'd1,
    ST_NO_ROOT   = 3'd2,
    ST_FETCH_ERR = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_DENIED    = 3'd5,
    ST_RESERVED  = 3'd6
  } status_e;

  typedef enum logic {
    KIND_TRANSLATE = 1'b0,
    KIND_RESPONSE  = 1'b1
  } kind_e;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_DONE = 1'b1
  } res_kind_e;

  // Walker state carried between requests
  typedef struct packed {
    logic              busy;
    logic [1:0]        level;
    logic [GaW-1:0]    ga;
    logic [1:0]        acc;
    logic [FrameW-1:0] frame;
  } walk_state_t;

  // One accepted input request
  typedef struct packed {
    logic            kind;
    logic [GaW-1:0]  guest_address;
    logic [1:0]      access_type;
    logic [RegW-1:0] entry_data;
    logic            fetch_failed;
  } in_item_t;

  // One result
  typedef struct packed {
    logic           result_kind;
    logic [PaW-1:0] read_address;
    logic [PaW-1:0] translated_address;
    logic [2:0]     status;
    logic [1:0]     walk_level;
  } out_item_t;

  // Index of the table entry for a level
  function automatic logic [IdxW-1:0] level_index(logic [1:0] lvl, logic [GaW-1:0] ga);
    logic [IdxW-1:0] idx;
    case (lvl)
      LvlTop:  idx = ga[47:39];
      Lvl1G:   idx = ga[38:30];
      Lvl2M:   idx = ga[29:21];
      default: idx = ga[20:12];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

/* design/nept_step.sv */
`default_nettype none
module nept_step (
  input  wire  nept_pkg::in_item_t    item_i,
  input  wire  nept_pkg::walk_state_t state_i,
  input  wire  logic [63:0]           root_i,
  output nept_pkg::walk_state_t       state_o,
  output logic                        emit_o,
  output nept_pkg::out_item_t         result_o
);

  logic        emit_read;
  logic [63:0] pte;
  logic        acc_ok;
  logic        is_large;
  logic [63:0] xlat;

  assign pte      = item_i.entry_data;
  assign acc_ok   = pte[state_i.acc];
  assign is_large = ((state_i.level == nept_pkg::Lvl1G) ||
                     (state_i.level == nept_pkg::Lvl2M))
                    && pte[nept_pkg::BitLarge];

  // Decide the outcome of one request and the next walker state
  always_comb begin
    state_o   = state_i;
    emit_o    = 1'b0;
    emit_read = 1'b0;
    result_o  = '0;
    xlat      = '0;
    if (item_i.kind == nept_pkg::KIND_TRANSLATE) begin
      if (!state_i.busy) begin
        emit_o = 1'b1;
        if (item_i.access_type == nept_pkg::ACC_INVALID) begin
          result_o.result_kind = nept_pkg::RES_DONE;
          result_o.status      = nept_pkg::ST_BAD_ACC;
        end else if ((root_i & nept_pkg::AddrMask) == 64'd0) begin
          result_o.result_kind = nept_pkg::RES_DONE;
          result_o.status      = nept_pkg::ST_NO_ROOT;
        end else begin
          emit_read      = 1'b1;
          state_o.busy   = 1'b1;
          state_o.level  = nept_pkg::LvlTop;
          state_o.ga     = item_i.guest_address;
          state_o.acc    = item_i.access_type;
          state_o.frame  = root_i[51:12];
        end
      end
    end else if (state_i.busy) begin
      emit_o               = 1'b1;
      result_o.result_kind = nept_pkg::RES_DONE;
      result_o.walk_level  = state_i.level;
      state_o.busy         = 1'b0;
      if (item_i.fetch_failed) begin
        result_o.status = nept_pkg::ST_FETCH_ERR;
      end else if (pte[2:0] == 3'd0) begin
        result_o.status = nept_pkg::ST_EMPTY;
      end else if (!acc_ok) begin
        result_o.status = nept_pkg::ST_DENIED;
      end else if (is_large && (state_i.level == nept_pkg::Lvl1G)) begin
        if ((pte & nept_pkg::Rsv1G) != 64'd0) begin
          result_o.status = nept_pkg::ST_RESERVED;
        end else begin
          xlat = (pte & nept_pkg::Addr1G) | ({16'd0, state_i.ga} & nept_pkg::Off1G);
        end
      end else if (is_large) begin
        if ((pte & nept_pkg::Rsv2M) != 64'd0) begin
          result_o.status = nept_pkg::ST_RESERVED;
        end else begin
          xlat = (pte & nept_pkg::Addr2M) | ({16'd0, state_i.ga} & nept_pkg::Off2M);
        end
      end else if (state_i.level == nept_pkg::LvlLeaf) begin
        xlat = (pte & nept_pkg::AddrMask) | ({16'd0, state_i.ga} & nept_pkg::Off4K);
      end else begin
        // Descend one level
        emit_read            = 1'b1;
        state_o.busy         = 1'b1;
        state_o.level        = state_i.level + 2'd1;
        state_o.frame        = pte[51:12];
      end
      result_o.translated_address = xlat[51:0];
    end

    // Build the table entry read from the updated state
    if (emit_read) begin
      result_o.result_kind  = nept_pkg::RES_READ;
      result_o.status       = nept_pkg::ST_OK;
      result_o.translated_address = '0;
      result_o.walk_level   = state_o.level;
      result_o.read_address = {state_o.frame,
                               nept_pkg::level_index(state_o.level, state_o.ga), 3'd0};
    end
  end

endmodule
`default_nettype wire

/* design/nested_ept_table_walker_top.sv */
// Path: a request is captured in the input register and its result then in the result register,
// which drives the outputs; requests that cause no result leave nothing.
// Throughput: one request per cycle, limited only by the result register draining.
// Reset: rst_ni asynchronously clears the walker to idle, the root pointer to zero
// and both pipeline registers to empty.
`default_nettype none
module nested_ept_table_walker_top (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_we_i,
  input  wire  logic [63:0] cfg_wdata_i,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  logic        kind_i,
  input  wire  logic [47:0] guest_address_i,
  input  wire  logic [1:0]  access_type_i,
  input  wire  logic [63:0] entry_data_i,
  input  wire  logic        fetch_failed_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output logic              result_kind_o,
  output logic [51:0]       read_address_o,
  output logic [51:0]       translated_address_o,
  output logic [2:0]        status_o,
  output logic [1:0]        walk_level_o
);

  logic [63:0]           root_ptr_q;
  logic                  in_valid_q;
  nept_pkg::in_item_t    in_item_q;
  nept_pkg::walk_state_t state_q;
  nept_pkg::walk_state_t state_d;
  logic                  out_valid_q;
  nept_pkg::out_item_t   out_item_q;
  logic                  out_free;
  logic                  advance;
  logic                  emit;
  nept_pkg::out_item_t   result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Hold the root pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ptr_q <= '0;
    end else if (cfg_we_i) begin
      root_ptr_q <= cfg_wdata_i;
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= '{kind: kind_i, guest_address: guest_address_i,
                     access_type: access_type_i, entry_data: entry_data_i,
                     fetch_failed: fetch_failed_i};
    end
  end

  nept_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .root_i   (root_ptr_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  // Advance the walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = out_item_q.result_kind;
  assign read_address_o       = out_item_q.read_address;
  assign translated_address_o = out_item_q.translated_address;
  assign status_o             = out_item_q.status;
  assign walk_level_o         = out_item_q.walk_level;

endmodule
`default_nettype wire
